### sv/vmc_pkg.sv
// ----------------------------------------------------------------------------
// vmc_pkg
// Shared types for the vector magnitude clamp pipeline.
// ----------------------------------------------------------------------------
package vmc_pkg;

  localparam logic OP_SET   = 1'b0;
  localparam logic OP_CLAMP = 1'b1;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_ZERO,
    MODE_SCALE
  } vmc_mode_t;

  typedef struct packed {
    logic      valid;
    vmc_mode_t mode;
  } vmc_ctl_t;

endpackage

### sv/vector_magnitude_clamp_2d.sv
// Throughput: one word per cycle; the whole row of cells advances together,
// held only while the output register waits to be taken.
// Depth is set by the square-root cells (one root bit each) and the
// division cells (one quotient bit each). Reset clears all valid flags.
// ----------------------------------------------------------------------------
// vector_magnitude_clamp_2d
// Rescales or clamps a 2D fixed-point vector to a given length.
// ----------------------------------------------------------------------------
module vector_magnitude_clamp_2d import vmc_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic [WORD_WIDTH-1:0] in_vec_x,
  input  logic [WORD_WIDTH-1:0] in_vec_y,
  input  logic [WORD_WIDTH-1:0] in_magnitude,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [WORD_WIDTH-1:0] out_res_x,
  output logic [WORD_WIDTH-1:0] out_res_y,
  output logic                  out_was_changed
);

  localparam int W = WORD_WIDTH;
  // the ratio is scale free: the fraction point only fixes the word's meaning
  localparam int FB = FRAC_BITS;

  logic en;

  vmc_ctl_t       s_ctl  [W+1];
  logic [2*W-1:0] s_rad  [W+1];
  logic [W+1:0]   s_rem  [W+1];
  logic [W-1:0]   s_root [W+1];
  logic [2*W-1:0] s_px   [W+1];
  logic [2*W-1:0] s_py   [W+1];
  logic [W-1:0]   s_x    [W+1];
  logic [W-1:0]   s_y    [W+1];

  vmc_ctl_t       d_ctl  [W+1];
  logic [W-1:0]   d_len  [W+1];
  logic [2*W-1:0] d_px   [W+1];
  logic [2*W-1:0] d_py   [W+1];
  logic [W-1:0]   d_rx   [W+1];
  logic [W-1:0]   d_ry   [W+1];
  logic [W-1:0]   d_qx   [W+1];
  logic [W-1:0]   d_qy   [W+1];
  logic [W-1:0]   d_x    [W+1];
  logic [W-1:0]   d_y    [W+1];

  logic         out_valid_r, chg_r;
  logic [W-1:0] res_x_r, res_y_r;
  logic [W-1:0] rx_nxt, ry_nxt;
  vmc_ctl_t     fin;

  // hold everything while the output word is stalled
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en && (FB >= 0);

  vmc_front #(.W(W)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(in_valid && in_ready), .op_i(in_operation),
    .x_i(in_vec_x), .y_i(in_vec_y), .m_i(in_magnitude),
    .ctl_o(s_ctl[0]), .sq_o(s_rad[0]), .px_o(s_px[0]), .py_o(s_py[0]),
    .x_o(s_x[0]), .y_o(s_y[0])
  );

  assign s_rem[0]  = '0;
  assign s_root[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_sqrt
    vmc_sqrt_cell #(.W(W), .IDX(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .ctl_i(s_ctl[i]), .rad_i(s_rad[i]), .rem_i(s_rem[i]), .root_i(s_root[i]),
      .px_i(s_px[i]), .py_i(s_py[i]), .x_i(s_x[i]), .y_i(s_y[i]),
      .ctl_o(s_ctl[i+1]), .rad_o(s_rad[i+1]), .rem_o(s_rem[i+1]),
      .root_o(s_root[i+1]), .px_o(s_px[i+1]), .py_o(s_py[i+1]),
      .x_o(s_x[i+1]), .y_o(s_y[i+1])
    );
  end

  // upper half of each product starts the partial remainder
  assign d_ctl[0] = s_ctl[W];
  assign d_len[0] = s_root[W];
  assign d_px[0]  = s_px[W];
  assign d_py[0]  = s_py[W];
  assign d_rx[0]  = s_px[W][2*W-1:W];
  assign d_ry[0]  = s_py[W][2*W-1:W];
  assign d_qx[0]  = '0;
  assign d_qy[0]  = '0;
  assign d_x[0]   = s_x[W];
  assign d_y[0]   = s_y[W];

  for (genvar j = 0; j < W; j++) begin : g_div
    vmc_div_cell #(.W(W), .IDX(j)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .ctl_i(d_ctl[j]), .len_i(d_len[j]), .px_i(d_px[j]), .py_i(d_py[j]),
      .rx_i(d_rx[j]), .ry_i(d_ry[j]), .qx_i(d_qx[j]), .qy_i(d_qy[j]),
      .x_i(d_x[j]), .y_i(d_y[j]),
      .ctl_o(d_ctl[j+1]), .len_o(d_len[j+1]), .px_o(d_px[j+1]), .py_o(d_py[j+1]),
      .rx_o(d_rx[j+1]), .ry_o(d_ry[j+1]), .qx_o(d_qx[j+1]), .qy_o(d_qy[j+1]),
      .x_o(d_x[j+1]), .y_o(d_y[j+1])
    );
  end

  assign fin = d_ctl[W];

  always_comb begin
    unique case (fin.mode)
      MODE_ZERO: begin
        rx_nxt = '0;
        ry_nxt = '0;
      end
      MODE_SCALE: begin
        rx_nxt = d_x[W][W-1] ? (~d_qx[W] + 1'b1) : d_qx[W];
        ry_nxt = d_y[W][W-1] ? (~d_qy[W] + 1'b1) : d_qy[W];
      end
      default: begin
        rx_nxt = d_x[W];
        ry_nxt = d_y[W];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fin.valid;
    end
    if (en) begin
      res_x_r <= rx_nxt;
      res_y_r <= ry_nxt;
      chg_r   <= (rx_nxt != d_x[W]) || (ry_nxt != d_y[W]);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_res_x       = res_x_r;
  assign out_res_y       = res_y_r;
  assign out_was_changed = chg_r;

endmodule

### sv/vmc_front.sv
// ----------------------------------------------------------------------------
// vmc_front
// Squares, scaled products and the pass/zero/scale decision (two stages).
// ----------------------------------------------------------------------------
module vmc_front import vmc_pkg::*; #(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_i,
  input  logic               op_i,
  input  logic [W-1:0]       x_i,
  input  logic [W-1:0]       y_i,
  input  logic [W-1:0]       m_i,
  output vmc_ctl_t           ctl_o,
  output logic [2*W-1:0]     sq_o,
  output logic [2*W-1:0]     px_o,
  output logic [2*W-1:0]     py_o,
  output logic [W-1:0]       x_o,
  output logic [W-1:0]       y_o
);

  logic [W-1:0]   ax, ay, am;
  logic           v1_r, op1_r;
  logic [2*W-1:0] xx_r, yy_r, mm_r, px1_r, py1_r;
  logic [W-1:0]   x1_r, y1_r, m1_r;
  logic [2*W-1:0] sq;
  logic           rescale;
  vmc_mode_t      mode_nxt;
  vmc_ctl_t       ctl_r;
  logic [2*W-1:0] sq_r, px_r, py_r;
  logic [W-1:0]   x_r, y_r;

  assign ax = x_i[W-1] ? (~x_i + 1'b1) : x_i;
  assign ay = y_i[W-1] ? (~y_i + 1'b1) : y_i;
  assign am = m_i[W-1] ? (~m_i + 1'b1) : m_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
    end
    if (en) begin
      op1_r <= op_i;
      xx_r  <= ax * ax;
      yy_r  <= ay * ay;
      mm_r  <= am * am;
      px1_r <= ax * am;
      py1_r <= ay * am;
      x1_r  <= x_i;
      y1_r  <= y_i;
      m1_r  <= m_i;
    end
  end

  assign sq      = xx_r + yy_r;
  assign rescale = !((op1_r == OP_CLAMP) && !(sq > mm_r));

  always_comb begin
    if (!rescale) begin
      mode_nxt = MODE_PASS;
    end else if (m1_r[W-1] || (m1_r == '0)) begin
      mode_nxt = MODE_ZERO;
    end else if (sq == '0) begin
      mode_nxt = MODE_PASS;
    end else begin
      mode_nxt = MODE_SCALE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '{valid: 1'b0, mode: MODE_PASS};
    end else if (en) begin
      ctl_r <= '{valid: v1_r, mode: mode_nxt};
    end
    if (en) begin
      sq_r <= sq;
      px_r <= px1_r;
      py_r <= py1_r;
      x_r  <= x1_r;
      y_r  <= y1_r;
    end
  end

  assign ctl_o = ctl_r;
  assign sq_o  = sq_r;
  assign px_o  = px_r;
  assign py_o  = py_r;
  assign x_o   = x_r;
  assign y_o   = y_r;

endmodule

### sv/vmc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vmc_sqrt_cell
// One root bit of a restoring integer square root; passes the word along.
// ----------------------------------------------------------------------------
module vmc_sqrt_cell import vmc_pkg::*; #(
  parameter int W   = 32,
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  vmc_ctl_t       ctl_i,
  input  logic [2*W-1:0] rad_i,
  input  logic [W+1:0]   rem_i,
  input  logic [W-1:0]   root_i,
  input  logic [2*W-1:0] px_i,
  input  logic [2*W-1:0] py_i,
  input  logic [W-1:0]   x_i,
  input  logic [W-1:0]   y_i,
  output vmc_ctl_t       ctl_o,
  output logic [2*W-1:0] rad_o,
  output logic [W+1:0]   rem_o,
  output logic [W-1:0]   root_o,
  output logic [2*W-1:0] px_o,
  output logic [2*W-1:0] py_o,
  output logic [W-1:0]   x_o,
  output logic [W-1:0]   y_o
);

  logic [W+3:0] cur, trial, diff;
  logic [W+1:0] rem_nxt;
  logic [W-1:0] root_nxt;
  vmc_ctl_t     ctl_r;
  logic [2*W-1:0] rad_r, px_r, py_r;
  logic [W+1:0] rem_r;
  logic [W-1:0] root_r, x_r, y_r;

  // bring down the next pair of radicand bits
  assign cur   = {rem_i, rad_i[2*W-1-2*IDX -: 2]};
  assign trial = {2'b00, root_i, 2'b01};
  assign diff  = cur - trial;

  always_comb begin
    if (cur >= trial) begin
      rem_nxt  = diff[W+1:0];
      root_nxt = {root_i[W-2:0], 1'b1};
    end else begin
      rem_nxt  = cur[W+1:0];
      root_nxt = {root_i[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '{valid: 1'b0, mode: MODE_PASS};
    end else if (en) begin
      ctl_r <= ctl_i;
    end
    if (en) begin
      rad_r  <= rad_i;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      px_r   <= px_i;
      py_r   <= py_i;
      x_r    <= x_i;
      y_r    <= y_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign px_o   = px_r;
  assign py_o   = py_r;
  assign x_o    = x_r;
  assign y_o    = y_r;

endmodule

### sv/vmc_div_cell.sv
// ----------------------------------------------------------------------------
// vmc_div_cell
// One quotient bit of two restoring divisions by the vector length.
// ----------------------------------------------------------------------------
module vmc_div_cell import vmc_pkg::*; #(
  parameter int W   = 32,
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  vmc_ctl_t       ctl_i,
  input  logic [W-1:0]   len_i,
  input  logic [2*W-1:0] px_i,
  input  logic [2*W-1:0] py_i,
  input  logic [W-1:0]   rx_i,
  input  logic [W-1:0]   ry_i,
  input  logic [W-1:0]   qx_i,
  input  logic [W-1:0]   qy_i,
  input  logic [W-1:0]   x_i,
  input  logic [W-1:0]   y_i,
  output vmc_ctl_t       ctl_o,
  output logic [W-1:0]   len_o,
  output logic [2*W-1:0] px_o,
  output logic [2*W-1:0] py_o,
  output logic [W-1:0]   rx_o,
  output logic [W-1:0]   ry_o,
  output logic [W-1:0]   qx_o,
  output logic [W-1:0]   qy_o,
  output logic [W-1:0]   x_o,
  output logic [W-1:0]   y_o
);

  logic [W:0]   curx, cury, lenw, dx, dy;
  logic         gx, gy;
  vmc_ctl_t     ctl_r;
  logic [2*W-1:0] px_r, py_r;
  logic [W-1:0] len_r, rx_r, ry_r, qx_r, qy_r, x_r, y_r;

  assign curx = {rx_i, px_i[W-1-IDX]};
  assign cury = {ry_i, py_i[W-1-IDX]};
  assign lenw = {1'b0, len_i};
  assign dx   = curx - lenw;
  assign dy   = cury - lenw;
  assign gx   = curx >= lenw;
  assign gy   = cury >= lenw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '{valid: 1'b0, mode: MODE_PASS};
    end else if (en) begin
      ctl_r <= ctl_i;
    end
    if (en) begin
      len_r <= len_i;
      px_r  <= px_i;
      py_r  <= py_i;
      rx_r  <= gx ? dx[W-1:0] : curx[W-1:0];
      ry_r  <= gy ? dy[W-1:0] : cury[W-1:0];
      qx_r  <= {qx_i[W-2:0], gx};
      qy_r  <= {qy_i[W-2:0], gy};
      x_r   <= x_i;
      y_r   <= y_i;
    end
  end

  assign ctl_o = ctl_r;
  assign len_o = len_r;
  assign px_o  = px_r;
  assign py_o  = py_r;
  assign rx_o  = rx_r;
  assign ry_o  = ry_r;
  assign qx_o  = qx_r;
  assign qy_o  = qy_r;
  assign x_o   = x_r;
  assign y_o   = y_r;

endmodule
